FILE: rtl/sle_pkg.sv
// ----------------------------------------------------------------------------
// sle_pkg
// Shared types, key codes and result descriptors for the serial line editor.
// ----------------------------------------------------------------------------
package sle_pkg;

    localparam int LINE_MAX_DEF   = 256;
    localparam int HIST_DEPTH_DEF = 10;

    localparam logic [7:0] KEY_ESC     = 8'h1B;
    localparam logic [7:0] KEY_BRACKET = 8'h5B;
    localparam logic [7:0] KEY_UP      = 8'h41;
    localparam logic [7:0] KEY_DOWN    = 8'h42;
    localparam logic [7:0] KEY_CR      = 8'h0D;
    localparam logic [7:0] KEY_BS      = 8'h08;
    localparam logic [7:0] KEY_SPACE   = 8'h20;
    localparam logic [7:0] KEY_TILDE   = 8'h7E;

    typedef enum logic [1:0] {
        KIND_ECHO = 2'd0,
        KIND_LINE = 2'd1,
        KIND_READ = 2'd2
    } kind_t;

    // What one accepted item produces on the result side
    typedef enum logic [2:0] {
        OP_READ      = 3'd0,
        OP_LINE      = 3'd1,
        OP_BS        = 3'd2,
        OP_ECHO      = 3'd3,
        OP_ECHO_LINE = 3'd4
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [7:0]  chr;
        logic [8:0]  len;
        logic [4:0]  hist;
    } desc_t;

    function automatic logic [1:0] op_count(input op_t op);
        logic [1:0] n;
        unique case (op)
            OP_BS:        n = 2'd3;
            OP_ECHO_LINE: n = 2'd2;
            default:      n = 2'd1;
        endcase
        return n;
    endfunction

endpackage

FILE: rtl/serial_line_editor_top.sv
// ----------------------------------------------------------------------------
// serial_line_editor_top
// Terminal line editor: echo, backspace, arrow history position, line store.
// ----------------------------------------------------------------------------
// An input item's first result is offered in the cycle after acceptance.
// Results: one item per cycle while m_tready is high, 1 to 3 per input,
//   as the result register sets; an input with no result leaves it free.
// Reset: clears escape, arrow, line count, history, result valid and index;
//   the store is not cleared.
module serial_line_editor_top
    import sle_pkg::*;
#(
    parameter int LINE_MAX   = LINE_MAX_DEF,
    parameter int HIST_DEPTH = HIST_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic        s_tuser,    // command
    input  logic [15:0] s_tdata,    // rx_byte[7:0], read_index[15:8]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic        m_tlast,
    output logic [1:0]  m_tuser,    // kind
    output logic [23:0] m_tdata     // data_byte[7:0], line_length[16:8],
                                    // history_pos[21:17], zero[23:22]
);

    localparam int AW = $clog2(LINE_MAX);

    logic          acc;
    logic          load;
    logic          free;
    desc_t         desc;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    rd_data;

    assign s_tready = free;
    assign acc      = s_tvalid && s_tready;

    sle_edit #(
        .LINE_MAX   (LINE_MAX),
        .HIST_DEPTH (HIST_DEPTH)
    ) u_edit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .acc     (acc),
        .command (s_tuser),
        .rx_byte (s_tdata[7:0]),
        .load    (load),
        .desc    (desc),
        .wr_en   (wr_en),
        .wr_addr (wr_addr)
    );

    sle_store #(
        .LINE_MAX (LINE_MAX)
    ) u_store (
        .aclk     (aclk),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (s_tdata[7:0]),
        .rd_en    (acc && s_tuser),
        .rd_index (s_tdata[15:8]),
        .rd_data  (rd_data)
    );

    sle_emit u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (load),
        .desc_in  (desc),
        .rd_data  (rd_data),
        .free     (free),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata)
    );

endmodule

FILE: rtl/sle_store.sv
// ----------------------------------------------------------------------------
// sle_store
// Line store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sle_store
    import sle_pkg::*;
#(
    parameter int LINE_MAX = LINE_MAX_DEF
) (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [$clog2(LINE_MAX)-1:0] wr_addr,
    input  logic [7:0]                  wr_data,
    input  logic                        rd_en,
    input  logic [7:0]                  rd_index,
    output logic [7:0]                  rd_data
);

    localparam int AW = $clog2(LINE_MAX);
    localparam int XW = ((AW > 8) ? AW : 8) + 1;

    logic [7:0]    mem [LINE_MAX];
    logic [XW-1:0] idx_ext;
    logic          in_range;

    assign idx_ext  = XW'(rd_index);
    assign in_range = idx_ext < XW'(LINE_MAX);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Indexes beyond the store read as zero
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= in_range ? mem[idx_ext[AW-1:0]] : 8'h00;
        end
    end

endmodule

FILE: rtl/sle_edit.sv
// ----------------------------------------------------------------------------
// sle_edit
// Edit state: escape decoding, history position, line count and store write.
// ----------------------------------------------------------------------------
module sle_edit
    import sle_pkg::*;
#(
    parameter int LINE_MAX   = LINE_MAX_DEF,
    parameter int HIST_DEPTH = HIST_DEPTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        acc,
    input  logic                        command,
    input  logic [7:0]                  rx_byte,
    output logic                        load,
    output desc_t                       desc,
    output logic                        wr_en,
    output logic [$clog2(LINE_MAX)-1:0] wr_addr
);

    localparam int AW  = $clog2(LINE_MAX);
    localparam int HPW = $clog2(HIST_DEPTH + 1);

    logic           esc_reg,   esc_next;
    logic           arrow_reg, arrow_next;
    logic [AW-1:0]  count_reg, count_next;
    // history position plus one: zero means no recall
    logic [HPW-1:0] hist_reg,  hist_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            esc_reg   <= 1'b0;
            arrow_reg <= 1'b0;
            count_reg <= '0;
            hist_reg  <= '0;
        end else begin
            esc_reg   <= esc_next;
            arrow_reg <= arrow_next;
            count_reg <= count_next;
            hist_reg  <= hist_next;
        end
    end

    assign wr_addr = count_reg;

    always_comb begin
        esc_next   = esc_reg;
        arrow_next = arrow_reg;
        count_next = count_reg;
        hist_next  = hist_reg;
        load       = 1'b0;
        wr_en      = 1'b0;
        desc.op    = OP_READ;
        desc.chr   = rx_byte;
        desc.len   = 9'(count_reg);
        if (acc) begin
            if (command) begin
                load    = 1'b1;
                desc.op = OP_READ;
            end else if (esc_reg) begin
                arrow_next = (rx_byte == KEY_BRACKET);
                esc_next   = 1'b0;
            end else if (arrow_reg) begin
                if (rx_byte == KEY_UP && hist_reg != HPW'(HIST_DEPTH)) begin
                    hist_next = hist_reg + HPW'(1);
                end else if (rx_byte == KEY_DOWN && hist_reg != '0) begin
                    hist_next = hist_reg - HPW'(1);
                end
                arrow_next = 1'b0;
            end else if (rx_byte == KEY_CR) begin
                load       = 1'b1;
                desc.op    = OP_LINE;
                count_next = '0;
            end else if (rx_byte == KEY_BS) begin
                if (count_reg != '0) begin
                    load       = 1'b1;
                    desc.op    = OP_BS;
                    count_next = count_reg - AW'(1);
                end
            end else if (rx_byte == KEY_ESC) begin
                esc_next = 1'b1;
            end else if (rx_byte >= KEY_SPACE && rx_byte <= KEY_TILDE) begin
                load  = 1'b1;
                wr_en = 1'b1;
                if (count_reg == AW'(LINE_MAX - 1)) begin
                    // store full: report the line and empty it
                    desc.op    = OP_ECHO_LINE;
                    desc.len   = 9'(LINE_MAX);
                    count_next = '0;
                end else begin
                    desc.op    = OP_ECHO;
                    count_next = count_reg + AW'(1);
                end
            end
        end
        desc.hist = 5'(hist_next) - 5'd1;
    end

    a_esc_arrow_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(esc_reg && arrow_reg))
        else $error("escape and arrow sequence both pending");

    a_hist_range: assert property (@(posedge aclk) disable iff (!aresetn)
        hist_reg <= HPW'(HIST_DEPTH))
        else $error("history position beyond depth");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= AW'(LINE_MAX - 1))
        else $error("line count beyond store");

endmodule

FILE: rtl/sle_emit.sv
// ----------------------------------------------------------------------------
// sle_emit
// Result register: holds one descriptor and hands out its results in order.
// ----------------------------------------------------------------------------
module sle_emit
    import sle_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load,
    input  desc_t       desc_in,
    input  logic [7:0]  rd_data,
    output logic        free,
    input  logic        m_tready,
    output logic        m_tvalid,
    output logic        m_tlast,
    output logic [1:0]  m_tuser,
    output logic [23:0] m_tdata
);

    logic       valid_reg, valid_next;
    logic [1:0] idx_reg,   idx_next;
    desc_t      desc_reg,  desc_next;
    logic [1:0] cnt;
    kind_t      kind;
    logic [7:0] data_out;
    logic [8:0] len_out;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        desc_reg <= desc_next;
    end

    assign cnt      = op_count(desc_reg.op);
    assign m_tvalid = valid_reg;
    assign m_tlast  = (idx_reg == cnt - 2'd1);
    assign free     = !valid_reg || (m_tready && m_tlast);

    always_comb begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        desc_next  = desc_reg;
        if (load) begin
            valid_next = 1'b1;
            idx_next   = 2'd0;
            desc_next  = desc_in;
        end else if (valid_reg && m_tready) begin
            if (m_tlast) begin
                valid_next = 1'b0;
            end else begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_comb begin
        kind     = KIND_ECHO;
        data_out = 8'h00;
        len_out  = 9'd0;
        unique case (desc_reg.op)
            OP_READ: begin
                kind     = KIND_READ;
                data_out = rd_data;
            end
            OP_LINE: begin
                kind    = KIND_LINE;
                len_out = desc_reg.len;
            end
            OP_BS: begin
                data_out = (idx_reg == 2'd1) ? KEY_SPACE : KEY_BS;
            end
            OP_ECHO: begin
                data_out = desc_reg.chr;
            end
            OP_ECHO_LINE: begin
                if (idx_reg == 2'd0) begin
                    data_out = desc_reg.chr;
                end else begin
                    kind    = KIND_LINE;
                    len_out = desc_reg.len;
                end
            end
            default: begin
                kind = KIND_ECHO;
            end
        endcase
    end

    assign m_tuser = kind;
    assign m_tdata = {2'b00, desc_reg.hist, len_out, data_out};

    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> (idx_reg < cnt))
        else $error("result index beyond descriptor count");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> free)
        else $error("descriptor loaded over pending results");

    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && m_tready && m_tlast && !load) |=> !valid_reg)
        else $error("result register not emptied after final item");

endmodule
